// File: rtl/jse_pkg.sv
// shared types, constants and helper functions for the json string escaper
package jse_pkg;

    localparam int JSE_FIFO_DEPTH = 4;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_string;
        logic       last_of_string;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_item;
        logic       end_of_string;
    } t_out_req;

    typedef enum logic [2:0] {
        MK_NONE,
        MK_RAW,
        MK_ESC2,
        MK_U1,
        MK_U2
    } t_main_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OPEN,
        ST_PRE,
        ST_MAIN,
        ST_POST,
        ST_CLOSE
    } t_bk_state;

    typedef struct packed {
        logic            q_open;
        logic [1:0]      pre_n;
        logic [2:0][7:0] pre_b;
        t_main_kind      kind;
        logic [7:0]      m_char;
        logic [15:0]     u_hi;
        logic [15:0]     u_lo;
        logic [1:0]      post_n;
        logic [2:0][7:0] post_b;
        logic            q_close;
    } t_cmd;

    typedef struct packed {
        logic has_open;
        logic has_pre;
        logic has_main;
        logic has_post;
        logic has_close;
    } t_ph_flags;

    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd0;
        if (b[7:5] == 3'b110) begin
            n = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            n = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            n = 3'd4;
        end
        return n;
    endfunction

    function automatic logic [7:0] esc_letter(input logic [7:0] c);
        logic [7:0] e;
        unique case (c)
            8'h22:   e = 8'h22;
            8'h5C:   e = 8'h5C;
            8'h08:   e = 8'h62;
            8'h0C:   e = 8'h66;
            8'h0A:   e = 8'h6E;
            8'h0D:   e = 8'h72;
            8'h09:   e = 8'h74;
            default: e = 8'h00;
        endcase
        return e;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] h;
        if (d < 4'd10) begin
            h = 8'h30 + {4'b0, d};
        end else begin
            h = 8'h57 + {4'b0, d};
        end
        return h;
    endfunction

    function automatic logic [3:0] main_len(input t_main_kind k);
        logic [3:0] n;
        unique case (k)
            MK_RAW:  n = 4'd1;
            MK_ESC2: n = 4'd2;
            MK_U1:   n = 4'd6;
            MK_U2:   n = 4'd12;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic t_ph_flags cmd_flags(input t_cmd c);
        t_ph_flags f;
        f.has_open  = c.q_open;
        f.has_pre   = (c.pre_n != 2'd0);
        f.has_main  = (c.kind != MK_NONE);
        f.has_post  = (c.post_n != 2'd0);
        f.has_close = c.q_close;
        return f;
    endfunction

    // next phase with characters to send, idle when none is left
    function automatic t_bk_state next_phase(input t_bk_state st, input t_ph_flags f);
        t_bk_state n;
        logic      o_ok, p_ok, m_ok, q_ok;
        o_ok = (st == ST_IDLE);
        p_ok = o_ok || (st == ST_OPEN);
        m_ok = p_ok || (st == ST_PRE);
        q_ok = m_ok || (st == ST_MAIN);
        if (o_ok && f.has_open) begin
            n = ST_OPEN;
        end else if (p_ok && f.has_pre) begin
            n = ST_PRE;
        end else if (m_ok && f.has_main) begin
            n = ST_MAIN;
        end else if (q_ok && f.has_post) begin
            n = ST_POST;
        end else if (st != ST_CLOSE && f.has_close) begin
            n = ST_CLOSE;
        end else begin
            n = ST_IDLE;
        end
        return n;
    endfunction

endpackage

// File: rtl/json_string_escaper.sv
// top level of the json string escaper
//
// Input channel: one string byte per request with first/last markers, valid
// and stall. Output channel: one character of the JSON literal per request,
// valid and stall, driven from a register. Config channel: one write of the
// utf-8 escape enable bit, valid and ready, always ready; write only when idle.
// A byte is taken every cycle while the command queue has room; the queue
// holds FIFO_DEPTH decoded bytes. The sequencer sends one character per cycle
// while the receiver takes them, so a byte that expands into n characters holds
// it until all are sent. On an idle block a byte passes the queue, command
// register and output register. A byte that only opens a utf-8 sequence sends
// nothing. When the receiver stalls the output register holds its character,
// the sequencer waits and the queue fills, then the input stalls.
// Synchronous active-low reset empties the queue and output, clears the
// pending utf-8 bytes and turns utf-8 escaping off.
module json_string_escaper
    import jse_pkg::*;
#(
    parameter int FIFO_DEPTH = JSE_FIFO_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_data,
    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    input  logic     i_cfg_data
);

    logic fifo_full;
    logic push;
    t_cmd push_cmd;
    logic pop;
    logic fifo_valid;
    t_cmd head;

    jse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_fifo_full (fifo_full),
        .o_push      (push),
        .o_push_cmd  (push_cmd)
    );

    jse_cmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (fifo_full),
        .i_pop      (pop),
        .o_valid    (fifo_valid),
        .o_head     (head)
    );

    jse_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo_valid (fifo_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

// File: rtl/jse_front.sv
// front end: takes input bytes, tracks pending utf-8 bytes, builds commands
module jse_front
    import jse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_in_req i_in_data,
    input  logic    i_cfg_valid,
    output logic    o_cfg_ready,
    input  logic    i_cfg_data,
    input  logic    i_fifo_full,
    output logic    o_push,
    output t_cmd    o_push_cmd
);

    logic            r_esc;
    logic [1:0]      r_cnt, n_cnt;
    logic [2:0][7:0] r_pb, n_pb;

    logic        accept;
    logic [7:0]  c;
    logic [1:0]  pc0;
    logic        cont;
    logic        hold;
    logic [2:0]  need;
    logic        complete;
    logic [20:0] cp;
    logic [20:0] rest;
    logic [7:0]  letter;
    t_cmd        cmd;
    logic        nonempty;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_fifo_full;
    assign accept      = i_in_valid && !i_fifo_full;

    always_comb begin
        c        = i_in_data.data_byte;
        pc0      = i_in_data.first_of_string ? 2'd0 : r_cnt;
        cont     = (c[7:6] == 2'b10);
        hold     = (pc0 != 2'd0) && r_esc && cont;
        need     = seq_len(r_pb[0]);
        complete = ({1'b0, pc0} + 3'd1) >= need;
        letter   = esc_letter(c);

        unique case (need)
            3'd2:    cp = {10'b0, r_pb[0][4:0], c[5:0]};
            3'd3:    cp = {5'b0, r_pb[0][3:0], r_pb[1][5:0], c[5:0]};
            default: cp = {r_pb[0][2:0], r_pb[1][5:0], r_pb[2][5:0], c[5:0]};
        endcase
        rest = cp - 21'h10000;

        cmd        = '0;
        cmd.kind   = MK_NONE;
        cmd.q_open = i_in_data.first_of_string;
        cmd.pre_b  = r_pb;
        cmd.pre_n  = ((pc0 != 2'd0) && !hold) ? pc0 : 2'd0;
        n_cnt      = 2'd0;
        n_pb       = r_pb;

        if (hold) begin
            if (complete) begin
                if (cp[20:16] != 5'd0) begin
                    cmd.kind = MK_U2;
                    cmd.u_hi = 16'hD800 + {5'b0, rest[20:10]};
                    cmd.u_lo = 16'hDC00 + {6'b0, rest[9:0]};
                end else begin
                    cmd.kind = MK_U1;
                    cmd.u_hi = cp[15:0];
                end
            end else begin
                n_pb[pc0] = c;
                n_cnt     = pc0 + 2'd1;
            end
        end else if (!c[7]) begin
            if (letter != 8'h00) begin
                cmd.kind   = MK_ESC2;
                cmd.m_char = letter;
            end else if (c < 8'h20) begin
                cmd.kind = MK_U1;
                cmd.u_hi = {8'h00, c};
            end else begin
                cmd.kind   = MK_RAW;
                cmd.m_char = c;
            end
        end else if (r_esc && (seq_len(c) >= 3'd2)) begin
            n_pb[0] = c;
            n_cnt   = 2'd1;
        end else begin
            cmd.kind   = MK_RAW;
            cmd.m_char = c;
        end

        cmd.post_b = n_pb;
        if (i_in_data.last_of_string) begin
            cmd.post_n  = n_cnt;
            cmd.q_close = 1'b1;
            n_cnt       = 2'd0;
        end

        nonempty = cmd.q_open || (cmd.pre_n != 2'd0) || (cmd.kind != MK_NONE)
                || (cmd.post_n != 2'd0) || cmd.q_close;
    end

    assign o_push     = accept && nonempty;
    assign o_push_cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_cfg_valid) begin
                r_esc <= i_cfg_data;
            end
            if (accept) begin
                r_cnt <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pb <= n_pb;
        end
    end

endmodule

// File: rtl/jse_cmd_fifo.sv
// command queue between the front end and the character sequencer
module jse_cmd_fifo
    import jse_pkg::*;
#(
    parameter int DEPTH = JSE_FIFO_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

endmodule

// File: rtl/jse_back.sv
// back end: walks one command and sends its characters through an output register
module jse_back
    import jse_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fifo_valid,
    input  t_cmd     i_head,
    output logic     o_pop,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_data
);

    t_cmd      r_cmd;
    t_bk_state r_state, n_state;
    logic [3:0] r_idx, n_idx;
    logic       r_out_valid;
    t_out_req   r_out_data;

    logic       out_take;
    logic       active;
    logic       step;
    logic [3:0] len;
    logic       at_end;
    t_bk_state  after;
    logic       fin_item;
    logic       load;
    logic [7:0] ch;
    logic       eos;
    logic       hi_half;
    logic [2:0] sub;
    logic [15:0] uval;

    always_comb begin
        unique case (r_state)
            ST_OPEN:  len = 4'd1;
            ST_PRE:   len = {2'b0, r_cmd.pre_n};
            ST_MAIN:  len = main_len(r_cmd.kind);
            ST_POST:  len = {2'b0, r_cmd.post_n};
            ST_CLOSE: len = 4'd1;
            default:  len = 4'd0;
        endcase
    end

    assign out_take = !r_out_valid || !i_out_stall;
    assign active   = (r_state != ST_IDLE);
    assign step     = active && out_take;
    assign at_end   = (r_idx == (len - 4'd1));
    assign after    = next_phase(r_state, cmd_flags(r_cmd));
    assign fin_item = at_end && (after == ST_IDLE);
    assign load     = i_fifo_valid && (!active || (step && fin_item));
    assign o_pop    = load;

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        if (step) begin
            if (at_end) begin
                n_state = after;
                n_idx   = 4'd0;
            end else begin
                n_idx = r_idx + 4'd1;
            end
        end
        if (load) begin
            n_state = next_phase(ST_IDLE, cmd_flags(i_head));
            n_idx   = 4'd0;
        end
    end

    // character for the current position
    always_comb begin
        hi_half = (r_idx >= 4'd6);
        sub     = hi_half ? 3'(r_idx - 4'd6) : r_idx[2:0];
        uval    = hi_half ? r_cmd.u_lo : r_cmd.u_hi;
        ch      = 8'h00;
        eos     = 1'b0;
        unique case (r_state)
            ST_OPEN:  ch = CH_QUOTE;
            ST_PRE:   ch = r_cmd.pre_b[r_idx[1:0]];
            ST_POST:  ch = r_cmd.post_b[r_idx[1:0]];
            ST_CLOSE: begin
                ch  = CH_QUOTE;
                eos = 1'b1;
            end
            ST_MAIN: begin
                unique case (r_cmd.kind)
                    MK_RAW:  ch = r_cmd.m_char;
                    MK_ESC2: ch = (r_idx == 4'd0) ? CH_BSLASH : r_cmd.m_char;
                    MK_U1, MK_U2: begin
                        unique case (sub)
                            3'd0:    ch = CH_BSLASH;
                            3'd1:    ch = CH_U;
                            3'd2:    ch = hex_char(uval[15:12]);
                            3'd3:    ch = hex_char(uval[11:8]);
                            3'd4:    ch = hex_char(uval[7:4]);
                            default: ch = hex_char(uval[3:0]);
                        endcase
                    end
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (out_take) begin
                r_out_valid <= step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_head;
        end
        if (out_take) begin
            r_out_data.out_char      <= ch;
            r_out_data.last_of_item  <= fin_item;
            r_out_data.end_of_string <= eos;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: tb/jse_checker.sv
// checker for the json string escaper: predicts each literal character and compares
`timescale 1ns / 100ps

module jse_checker
    import jse_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_in_req  i_in_data,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_out_req i_out_data,
    input  logic     i_cfg_valid,
    input  logic     i_cfg_ready,
    input  logic     i_cfg_data,
    output int       o_fail_count,
    output int       o_exp_count
);

    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] LT_B   = 8'h62;
    localparam logic [7:0] LT_F   = 8'h66;
    localparam logic [7:0] LT_N   = 8'h6E;
    localparam logic [7:0] LT_R   = 8'h72;
    localparam logic [7:0] LT_T   = 8'h74;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    localparam logic [20:0] BMP_MAX   = 21'h00FFFF;
    localparam logic [20:0] SUPP_BASE = 21'h010000;
    localparam logic [20:0] SURR_HI   = 21'h00D800;
    localparam logic [20:0] SURR_LO   = 21'h00DC00;
    localparam logic [20:0] LOW_TEN   = 21'h0003FF;

    localparam string HEX_DIGITS = "0123456789abcdef";

    logic       esc_on;
    logic [7:0] held [3];
    int         held_n;
    t_out_req   lit_chars [$];
    t_out_req   step_chars [$];

    function automatic void add_char(input logic [7:0] c, input logic eos);
        t_out_req r;
        r.out_char      = c;
        r.last_of_item  = 1'b0;
        r.end_of_string = eos;
        step_chars = {step_chars, r};
    endfunction

    function automatic void add_uesc(input logic [15:0] cu);
        add_char(CH_BSLASH, 1'b0);
        add_char(CH_U, 1'b0);
        add_char(HEX_DIGITS[cu[15:12]], 1'b0);
        add_char(HEX_DIGITS[cu[11:8]], 1'b0);
        add_char(HEX_DIGITS[cu[7:4]], 1'b0);
        add_char(HEX_DIGITS[cu[3:0]], 1'b0);
    endfunction

    function automatic int lead_len(input logic [7:0] b);
        int n;
        casez (b)
            8'b110?????: n = 2;
            8'b1110????: n = 3;
            8'b11110???: n = 4;
            default:     n = 0;
        endcase
        return n;
    endfunction

    function automatic void flush_held();
        for (int k = 0; k < held_n; k++) begin
            add_char(held[k], 1'b0);
        end
        held_n = 0;
    endfunction

    function automatic void ascii_char(input logic [7:0] c);
        logic [7:0] e;
        case (c)
            CH_QUOTE:  e = CH_QUOTE;
            CH_BSLASH: e = CH_BSLASH;
            CH_BS:     e = LT_B;
            CH_FF:     e = LT_F;
            CH_LF:     e = LT_N;
            CH_CR:     e = LT_R;
            CH_TAB:    e = LT_T;
            default:   e = 8'h00;
        endcase
        if (e != 8'h00) begin
            add_char(CH_BSLASH, 1'b0);
            add_char(e, 1'b0);
        end else if (c < CTRL_LIMIT) begin
            add_uesc({8'h00, c});
        end else begin
            add_char(c, 1'b0);
        end
    endfunction

    function automatic void plain_byte(input logic [7:0] c);
        if (!c[7]) begin
            ascii_char(c);
        end else if (esc_on && lead_len(c) >= 2) begin
            held[0] = c;
            held_n  = 1;
        end else begin
            add_char(c, 1'b0);
        end
    endfunction

    function automatic void add_code_point(input logic [20:0] cp);
        logic [20:0] rest, hi, lo;
        if (cp <= BMP_MAX) begin
            add_uesc(cp[15:0]);
        end else begin
            rest = cp - SUPP_BASE;
            hi   = SURR_HI + (rest >> 10);
            lo   = SURR_LO + (rest & LOW_TEN);
            add_uesc(hi[15:0]);
            add_uesc(lo[15:0]);
        end
    endfunction

    function automatic void predict_chars(input t_in_req r);
        logic [7:0]  c;
        logic [7:0]  sq [4];
        logic [20:0] cp;
        int          need;
        c = r.data_byte;
        step_chars.delete();
        if (r.first_of_string) begin
            held_n = 0;
            add_char(CH_QUOTE, 1'b0);
        end
        if (held_n > 0 && !esc_on) begin
            flush_held();
        end
        if (held_n > 0) begin
            if (c[7:6] == 2'b10) begin
                need = lead_len(held[0]);
                if (held_n + 1 >= need) begin
                    sq[0] = held[0];
                    sq[1] = held[1];
                    sq[2] = held[2];
                    sq[3] = 8'h00;
                    sq[held_n] = c;
                    case (need)
                        2:       cp = {10'b0, sq[0][4:0], sq[1][5:0]};
                        3:       cp = {5'b0, sq[0][3:0], sq[1][5:0], sq[2][5:0]};
                        default: cp = {sq[0][2:0], sq[1][5:0], sq[2][5:0], sq[3][5:0]};
                    endcase
                    held_n = 0;
                    add_code_point(cp);
                end else begin
                    held[held_n] = c;
                    held_n++;
                end
            end else begin
                flush_held();
                plain_byte(c);
            end
        end else begin
            plain_byte(c);
        end
        if (r.last_of_string) begin
            flush_held();
            add_char(CH_QUOTE, 1'b1);
        end
        if (step_chars.size() > 0) begin
            step_chars[step_chars.size() - 1].last_of_item = 1'b1;
        end
        lit_chars = {lit_chars, step_chars};
    endfunction

    always @(posedge i_clk) begin
        t_out_req want;
        if (!i_rst_n) begin
            esc_on = 1'b0;
            held_n = 0;
            held[0] = 8'h00;
            held[1] = 8'h00;
            held[2] = 8'h00;
            lit_chars.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (lit_chars.size() == 0) begin
                    $display("%0t: unexpected char: expected none, got %02h/%0b/%0b", $time,
                             i_out_data.out_char, i_out_data.last_of_item,
                             i_out_data.end_of_string);
                    o_fail_count++;
                end else begin
                    want = lit_chars.pop_front();
                    if (i_out_data.out_char !== want.out_char ||
                        i_out_data.last_of_item !== want.last_of_item ||
                        i_out_data.end_of_string !== want.end_of_string) begin
                        $display("%0t: char mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                                 $time, want.out_char, want.last_of_item, want.end_of_string,
                                 i_out_data.out_char, i_out_data.last_of_item,
                                 i_out_data.end_of_string);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_chars(i_in_data);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                esc_on = i_cfg_data;
            end
        end
        o_exp_count = lit_chars.size();
    end

endmodule

// File: tb/tb_top.sv
// testbench top for the json string escaper: stimulus, pacing and verdict
`timescale 1ns / 100ps

module tb_top
    import jse_pkg::*;
;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS  = 100;
    localparam int LONG_HOLD    = 400;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_stall;
    t_in_req  i_in_data = '0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_out_req o_out_data;
    logic     i_cfg_valid = 1'b0;
    logic     o_cfg_ready;
    logic     i_cfg_data = 1'b0;

    int fail_count;
    int exp_count;
    int cycles = 0;
    int items_sent = 0;
    int burst_left = 1;
    bit idle_on = 1'b0;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;
    logic [7:0] str_q [$];

    json_string_escaper uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    jse_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_exp_count  (exp_count)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver pacing, with one long hold-off on request
    initial begin : rx_pace
        int mode;
        int span;
        int k;
        forever begin
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                for (k = 0; k < LONG_HOLD; k++) begin
                    @(negedge i_clk);
                    i_out_stall = 1'b1;
                end
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 150);
            for (k = 0; k < span && !(hold_go && !hold_done); k++) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_out_stall = 1'b0;
                    1:       i_out_stall = ($urandom_range(0, 3) == 0);
                    2:       i_out_stall = ($urandom_range(0, 3) != 0);
                    default: i_out_stall = ((k % 6) < 2);
                endcase
            end
        end
    end

    task automatic offer(input t_in_req r);
        int gap;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data  = r;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        items_sent++;
        if (idle_on) begin
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(1, 6);
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (exp_count == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic v);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_string(input bit noisy);
        t_in_req r;
        foreach (str_q[k]) begin
            r.data_byte       = str_q[k];
            r.first_of_string = (k == 0);
            r.last_of_string  = (k == str_q.size() - 1);
            if (noisy && $urandom_range(0, 99) < 4) begin
                {r.first_of_string, r.last_of_string} = 2'($urandom_range(0, 3));
            end
            offer(r);
        end
    endtask

    // mostly well-formed text with valid utf-8, some broken sequences and stray bytes
    task automatic build_string(input int max_len);
        int         len;
        int         pick;
        int         n;
        int         conts;
        logic [7:0] b;
        str_q.delete();
        len = $urandom_range(1, max_len);
        while (str_q.size() < len) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                b = 8'($urandom_range(8'h20, 8'h7E));
                str_q = {str_q, b};
            end else if (pick < 45) begin
                b = 8'($urandom_range(8'h00, 8'h1F));
                str_q = {str_q, b};
            end else if (pick < 50) begin
                b = ($urandom_range(0, 1) != 0) ? CH_QUOTE : CH_BSLASH;
                str_q = {str_q, b};
            end else if (pick < 85) begin
                n = $urandom_range(2, 4);
                conts = (pick < 75) ? n - 1 : $urandom_range(0, n - 2);
                b = 8'($urandom());
                case (n)
                    2:       b = {3'b110, b[4:0]};
                    3:       b = {4'b1110, b[3:0]};
                    default: b = {5'b11110, b[2:0]};
                endcase
                str_q = {str_q, b};
                repeat (conts) begin
                    b = 8'($urandom());
                    b = {2'b10, b[5:0]};
                    str_q = {str_q, b};
                end
            end else if (pick < 90) begin
                b = 8'($urandom_range(8'h80, 8'hFF));
                str_q = {str_q, b};
            end else begin
                b = 8'($urandom_range(0, 255));
                str_q = {str_q, b};
            end
        end
    endtask

    initial begin : stimulus
        int  target;
        bit  paused;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: every short escape, controls, utf-8 of each length and the broken cases
        cfg_write(1'b1);
        str_q = '{CH_QUOTE, CH_BSLASH, 8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h00, 8'h1F, 8'h7F};
        send_string(1'b0);
        str_q = '{8'hC3, 8'hA9, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'hFF, 8'hE2, 8'h41};
        send_string(1'b0);
        offer('{8'hE2, 1'b1, 1'b0});
        offer('{8'hE2, 1'b1, 1'b0});
        offer('{8'h82, 1'b0, 1'b0});
        offer('{8'hAC, 1'b0, 1'b1});
        offer('{8'hF7, 1'b1, 1'b0});
        offer('{8'hBF, 1'b0, 1'b1});
        offer('{8'hC3, 1'b1, 1'b0});
        drain();
        cfg_write(1'b0);
        offer('{8'hA9, 1'b0, 1'b1});

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            cfg_write(ph == 0 ? 1'b0 : (ph == 1 ? 1'b1 : 1'($urandom_range(0, 1))));
            idle_on = (ph != 2);
            if (ph == 2) begin
                hold_go = 1'b1;
            end
            paused = 1'b0;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                build_string(($urandom_range(0, 9) == 0) ? 30 : 10);
                send_string(1'b1);
                if (ph == 3 && !paused && items_sent > target - PHASE_ITEMS / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (exp_count == 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
